### hdl/sw_dfr_pkg.sv
// ----------------------------------------------------------------------------
// sw_dfr_pkg
// types and constants shared by the sync word deframer
// ----------------------------------------------------------------------------
package sw_dfr_pkg;

    localparam int unsigned SYNC_BYTES = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT     = 2'd2;

    localparam logic [31:0] SYNC_WORD_RST      = 32'h7370_6F30;
    localparam logic [15:0] PAYLOAD_LENGTH_RST = 16'd64;
    localparam logic [15:0] IDLE_LIMIT_RST     = 16'd100;

    localparam logic [16:0] IDLE_MAX = 17'h1_FFFF;

    typedef enum logic [2:0] {
        EV_NONE            = 3'd0,
        EV_BYTE            = 3'd1,
        EV_LAST            = 3'd2,
        EV_SYNC_TIMEOUT    = 3'd3,
        EV_PAYLOAD_TIMEOUT = 3'd4
    } t_event;

    typedef struct packed {
        logic [31:0] sync_word;
        logic [15:0] payload_length;
        logic [15:0] idle_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data;
        logic [15:0] byte_index;
    } t_result;

endpackage

### hdl/sw_dfr_if.sv
// ----------------------------------------------------------------------------
// sw_dfr_if
// valid/ready channels for received bytes and for deframer events
// ----------------------------------------------------------------------------
interface sw_dfr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface sw_dfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data;
    logic [15:0] byte_index;

    modport source (output valid, output event_res, output data, output byte_index,
                    input ready);
    modport sink (input valid, input event_res, input data, input byte_index,
                  output ready);
endinterface

### hdl/sw_dfr_engine.sv
// ----------------------------------------------------------------------------
// sw_dfr_engine
// sync hunt, payload count and idle timeout state, one transaction per cycle while i_accept is high
// ----------------------------------------------------------------------------
module sw_dfr_engine
    import sw_dfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    logic        r_in_payload, n_in_payload;
    logic [1:0]  r_sync_matched, n_sync_matched;
    logic [15:0] r_payload_count, n_payload_count;
    logic [16:0] r_idle_count, n_idle_count;

    logic [7:0]  sync_cur;
    logic [16:0] idle_inc;
    logic [15:0] cnt_inc;

    always_comb begin
        case (r_sync_matched)
            2'd0:    sync_cur = i_cfg.sync_word[7:0];
            2'd1:    sync_cur = i_cfg.sync_word[15:8];
            2'd2:    sync_cur = i_cfg.sync_word[23:16];
            default: sync_cur = i_cfg.sync_word[31:24];
        endcase
    end

    assign idle_inc = (r_idle_count < IDLE_MAX) ? r_idle_count + 17'd1 : r_idle_count;
    assign cnt_inc  = r_payload_count + 16'd1;

    always_comb begin
        n_in_payload    = r_in_payload;
        n_sync_matched  = r_sync_matched;
        n_payload_count = r_payload_count;
        n_idle_count    = r_idle_count;
        o_result        = '{event_res: EV_NONE, data: 8'd0, byte_index: 16'd0};
        if (!i_op) begin
            n_idle_count = idle_inc;
            if (idle_inc > {1'b0, i_cfg.idle_limit}) begin
                o_result.event_res = r_in_payload ? EV_PAYLOAD_TIMEOUT : EV_SYNC_TIMEOUT;
                n_in_payload    = 1'b0;
                n_sync_matched  = 2'd0;
                n_payload_count = 16'd0;
                n_idle_count    = 17'd0;
            end
        end else begin
            n_idle_count = 17'd0;
            if (!r_in_payload) begin
                if (i_rx_byte == sync_cur) begin
                    if (r_sync_matched == 2'(SYNC_BYTES - 1)) begin
                        n_sync_matched  = 2'd0;
                        n_in_payload    = 1'b1;
                        n_payload_count = 16'd0;
                    end else begin
                        n_sync_matched = r_sync_matched + 2'd1;
                    end
                end else begin
                    // retry the breaking byte as the first sync byte
                    n_sync_matched = (i_rx_byte == i_cfg.sync_word[7:0]) ? 2'd1 : 2'd0;
                end
            end else begin
                o_result.data       = i_rx_byte;
                o_result.byte_index = r_payload_count;
                n_payload_count     = cnt_inc;
                if (cnt_inc == i_cfg.payload_length) begin
                    o_result.event_res = EV_LAST;
                    n_in_payload    = 1'b0;
                    n_sync_matched  = 2'd0;
                    n_payload_count = 16'd0;
                end else begin
                    o_result.event_res = EV_BYTE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload    <= 1'b0;
            r_sync_matched  <= 2'd0;
            r_payload_count <= 16'd0;
            r_idle_count    <= 17'd0;
        end else if (i_accept) begin
            r_in_payload    <= n_in_payload;
            r_sync_matched  <= n_sync_matched;
            r_payload_count <= n_payload_count;
            r_idle_count    <= n_idle_count;
        end
    end

endmodule

### hdl/sw_dfr_obuf.sv
// ----------------------------------------------------------------------------
// sw_dfr_obuf
// result register with skid stage, ready toward the engine is registered
// ----------------------------------------------------------------------------
module sw_dfr_obuf
    import sw_dfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_pop_ready,
    output t_result o_result
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign o_ready  = !r_skid_v;
    assign o_valid  = r_main_v;
    assign o_result = r_main;
    assign pop      = r_main_v && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
            end
        end else if (i_push) begin
            if (r_main_v) begin
                r_skid_v <= 1'b1;
            end else begin
                r_main_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_v ? r_skid : i_result;
        end else if (i_push) begin
            if (r_main_v) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

endmodule

### hdl/sync_word_deframer_with_timeout_core.sv
// ----------------------------------------------------------------------------
// sync_word_deframer_with_timeout_core
// hunts a four-byte sync word, passes a fixed-length payload, times out on idle
//
//   channel   dir   handshake           payload
//   i_rx      in    valid/ready         op, rx_byte
//   o_ev      out   valid/ready         event_res, data, byte_index
//   i_cfg_*   in    write enable only   index, 32-bit data
//
// one transaction accepted per cycle while ready is high, its event registered in the result register or skid stage
// the result register plus a skid stage hold up to two events
// ready drops only while both are full
// synchronous active-low reset loads the default register values
// ----------------------------------------------------------------------------
module sync_word_deframer_with_timeout_core
    import sw_dfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sw_dfr_in_if.sink             i_rx,
    sw_dfr_out_if.source          o_ev,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_result eng_result;
    t_result buf_result;
    logic    accept;
    logic    buf_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_word      <= SYNC_WORD_RST;
            r_cfg.payload_length <= PAYLOAD_LENGTH_RST;
            r_cfg.idle_limit     <= IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_WORD:      r_cfg.sync_word      <= i_cfg_data;
                CFG_PAYLOAD_LENGTH: r_cfg.payload_length <= i_cfg_data[15:0];
                CFG_IDLE_LIMIT:     r_cfg.idle_limit     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign i_rx.ready = buf_ready;
    assign accept     = i_rx.valid && buf_ready;

    sw_dfr_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_op      (i_rx.op),
        .i_rx_byte (i_rx.rx_byte),
        .i_cfg     (r_cfg),
        .o_result  (eng_result)
    );

    sw_dfr_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_result    (eng_result),
        .o_ready     (buf_ready),
        .o_valid     (o_ev.valid),
        .i_pop_ready (o_ev.ready),
        .o_result    (buf_result)
    );

    assign o_ev.event_res  = buf_result.event_res;
    assign o_ev.data       = buf_result.data;
    assign o_ev.byte_index = buf_result.byte_index;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sync word deframer: byte and idle-poll
// transactions go in over a valid/ready channel, every accepted transaction is
// run through a bit-accurate deframer predictor, and each event coming out is
// compared field by field against the oldest prediction. registers are
// rewritten between phases once the block is drained, and the phases vary their
// mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sw_dfr_pkg::*;

    typedef struct {
        logic       op;
        logic [7:0] rx_byte;
        logic       hold;
    } t_rx_item;

    localparam logic [31:0] DFLT_SYNC      = 32'h7370_6F30;
    localparam logic [15:0] DFLT_LEN       = 16'd64;
    localparam logic [15:0] DFLT_LIMIT     = 16'd100;
    localparam int          WATCHDOG_LIMIT = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sw_dfr_in_if  rx_if ();
    sw_dfr_out_if ev_if ();

    sync_word_deframer_with_timeout_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_if),
        .o_ev       (ev_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // deframer predictor state
    t_cfg        df_cfg;
    logic        in_frame;
    logic [1:0]  sync_hits;
    logic [15:0] frame_pos;
    logic [16:0] idle_run;

    t_rx_item rx_backlog[$];
    t_result  pending_events[$];
    t_rx_item next_item;
    t_result  want;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        rx_taken       = 1'b0;
    int          errors         = 0;
    int          n_checked      = 0;
    int          n_frames       = 0;
    int          n_timeouts     = 0;
    int          quiet_cycles   = 0;
    logic [15:0] top_index      = '0;

    function automatic logic [7:0] sync_at(input int pos);
        return df_cfg.sync_word[pos*8 +: 8];
    endfunction

    function automatic void clear_frame_state();
        in_frame  = 1'b0;
        sync_hits = '0;
        frame_pos = '0;
        idle_run  = '0;
    endfunction

    function automatic t_result deframe_step(input logic op, input logic [7:0] b);
        t_result r;
        r = '0;
        r.event_res = EV_NONE;
        if (!op) begin
            if (idle_run != '1) begin
                idle_run = idle_run + 17'd1;
            end
            if (idle_run > {1'b0, df_cfg.idle_limit}) begin
                r.event_res = in_frame ? EV_PAYLOAD_TIMEOUT : EV_SYNC_TIMEOUT;
                clear_frame_state();
            end
        end else begin
            idle_run = '0;
            if (!in_frame) begin
                if (b == sync_at(sync_hits)) begin
                    if (sync_hits == 2'd3) begin
                        sync_hits = '0;
                        in_frame  = 1'b1;
                        frame_pos = '0;
                    end else begin
                        sync_hits = sync_hits + 2'd1;
                    end
                end else begin
                    // a breaking byte may still start a new match
                    sync_hits = (b == sync_at(0)) ? 2'd1 : 2'd0;
                end
            end else begin
                r.data       = b;
                r.byte_index = frame_pos;
                frame_pos    = frame_pos + 16'd1;
                if (frame_pos == df_cfg.payload_length) begin
                    r.event_res = EV_LAST;
                    clear_frame_state();
                end else begin
                    r.event_res = EV_BYTE;
                end
            end
        end
        return r;
    endfunction

    function automatic void queue_rx(input logic op, input logic [7:0] b,
                                     input logic hold = 1'b0);
        t_rx_item it;
        it.op      = op;
        it.rx_byte = b;
        it.hold    = hold;
        rx_backlog.push_back(it);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor, event checker and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            df_cfg.sync_word      = DFLT_SYNC;
            df_cfg.payload_length = DFLT_LEN;
            df_cfg.idle_limit     = DFLT_LIMIT;
            clear_frame_state();
            pending_events.delete();
            rx_taken <= 1'b0;
            quiet_cycles = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_SYNC_WORD:      df_cfg.sync_word      = cfg_data;
                    CFG_PAYLOAD_LENGTH: df_cfg.payload_length = cfg_data[15:0];
                    CFG_IDLE_LIMIT:     df_cfg.idle_limit     = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (ev_if.valid && ev_if.ready) begin
                if (pending_events.size() == 0) begin
                    errors++;
                    $error("event with no transaction waiting: event_res %0d data %0h index %0d",
                           ev_if.event_res, ev_if.data, ev_if.byte_index);
                end else begin
                    want = pending_events.pop_front();
                    if (ev_if.event_res !== want.event_res) begin
                        errors++;
                        $error("event_res mismatch: expected %0d, got %0d",
                               want.event_res, ev_if.event_res);
                    end
                    if (ev_if.data !== want.data) begin
                        errors++;
                        $error("data mismatch: expected %0h, got %0h", want.data, ev_if.data);
                    end
                    if (ev_if.byte_index !== want.byte_index) begin
                        errors++;
                        $error("byte_index mismatch: expected %0d, got %0d",
                               want.byte_index, ev_if.byte_index);
                    end
                    n_checked++;
                    if (want.event_res == EV_LAST) begin
                        n_frames++;
                    end
                    if (want.event_res == EV_SYNC_TIMEOUT ||
                        want.event_res == EV_PAYLOAD_TIMEOUT) begin
                        n_timeouts++;
                    end
                    if ((want.event_res == EV_BYTE || want.event_res == EV_LAST) &&
                        want.byte_index > top_index) begin
                        top_index = want.byte_index;
                    end
                end
            end
            if (rx_if.valid && rx_if.ready) begin
                pending_events.push_back(deframe_step(rx_if.op, rx_if.rx_byte));
            end
            rx_taken <= rx_if.valid && rx_if.ready;
            if ((rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("** sync_word_deframer_with_timeout_core: FAILED **");
                $finish;
            end
        end
    end

    // byte driver and event sink
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
            ev_if.ready <= 1'b0;
        end else begin
            ev_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!rx_if.valid || rx_taken) begin
                if (rx_backlog.size() != 0 &&
                    !(rx_backlog[0].hold && pending_events.size() != 0) &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    next_item = rx_backlog.pop_front();
                    rx_if.valid   <= 1'b1;
                    rx_if.op      <= next_item.op;
                    rx_if.rx_byte <= next_item.rx_byte;
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] sync, input logic [15:0] plen,
                             input logic [15:0] lim, input int idle_pct,
                             input int stall_pct);
        // upper bits of the 16-bit registers get junk
        write_reg(CFG_SYNC_WORD, sync);
        write_reg(CFG_PAYLOAD_LENGTH, {16'($urandom), plen});
        write_reg(CFG_IDLE_LIMIT, {16'($urandom), lim});
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (rx_backlog.size() != 0 || rx_if.valid || pending_events.size() != 0);
    endtask

    task automatic gen_random(input int n);
        int made;
        int kind;
        int len;
        int gaps;
        int plen;
        int lim;
        int k;
        made = 0;
        plen = df_cfg.payload_length;
        lim  = df_cfg.idle_limit;
        while (made < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // sync word, then a full frame or a cut-off one
                for (k = 0; k < 4; k++) begin
                    queue_rx(1'b1, sync_at(k), k == 0 && $urandom_range(0, 14) == 0);
                end
                if (plen != 0 && plen <= 64 && $urandom_range(0, 3) != 0) begin
                    len = plen;
                end else begin
                    len = $urandom_range(0, (plen == 0 || plen > 9) ? 8 : plen - 1);
                end
                for (k = 0; k < len; k++) begin
                    if (lim > 0 && $urandom_range(0, 4) == 0) begin
                        gaps = $urandom_range(1, lim < 4 ? lim : 4);
                        repeat (gaps) queue_rx(1'b0, 8'($urandom));
                        made += gaps;
                    end
                    queue_rx(1'b1, 8'($urandom));
                end
                if (len != plen) begin
                    repeat (lim + 1) queue_rx(1'b0, 8'($urandom));
                    made += lim + 1;
                end
                made += 4 + len;
            end else if (kind < 75) begin
                // partial sync match broken by a wrong byte
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++) begin
                    queue_rx(1'b1, sync_at(k));
                end
                queue_rx(1'b1, $urandom_range(0, 1) ? sync_at(0) : 8'($urandom));
                made += len + 1;
            end else if (kind < 88) begin
                gaps = (lim > 120) ? 3 : lim + 1;
                repeat (gaps) queue_rx(1'b0, 8'($urandom));
                made += gaps;
            end else begin
                gaps = $urandom_range(1, 6);
                repeat (gaps) queue_rx(1'($urandom), 8'($urandom));
                made += gaps;
            end
        end
    endtask

    initial begin
        logic [8:0] dir_seq [27];
        int         j;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.op      = 1'b0;
        rx_if.rx_byte = '0;
        ev_if.ready   = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values
        gen_random(60);
        wait_drained();

        // sync bytes ff 00 c3 5a, three-byte frames, two idle polls allowed
        configure(32'h5AC3_00FF, 16'd3, 16'd2, 0, 0);
        dir_seq = '{9'h000, 9'h1FF, 9'h100, 9'h1FF, 9'h100, 9'h1C3, 9'h17E,
                    9'h1FF, 9'h100, 9'h1C3, 9'h15A,
                    9'h100, 9'h0AA, 9'h055, 9'h1FF, 9'h180,
                    9'h000, 9'h0FF, 9'h000,
                    9'h1FF, 9'h100, 9'h1C3, 9'h15A, 9'h155, 9'h000, 9'h000, 9'h000};
        foreach (dir_seq[i]) begin
            queue_rx(dir_seq[i][8], dir_seq[i][7:0]);
        end
        wait_drained();

        configure(32'($urandom), 16'd5, 16'd3, 0, 0);
        gen_random(80);
        wait_drained();
        configure(32'($urandom), 16'd1, 16'd0, 73, 0);
        gen_random(80);
        wait_drained();
        configure(32'h0000_0000, 16'd12, 16'd10, 0, 73);
        gen_random(80);
        wait_drained();
        configure(32'hFFFF_FFFF, 16'd7, 16'd4, 15, 15);
        gen_random(80);
        wait_drained();
        configure(32'($urandom), 16'hFFFF, 16'd1, 73, 0);
        gen_random(50);
        wait_drained();

        // zero length never ends a frame early, an idle run closes it
        configure(32'($urandom), 16'd0, 16'd3, 0, 0);
        for (j = 0; j < 4; j++) begin
            queue_rx(1'b1, sync_at(j));
        end
        repeat (20) queue_rx(1'b1, 8'($urandom));
        repeat (4) queue_rx(1'b0, 8'($urandom));
        repeat (4) queue_rx(1'b0, 8'($urandom));
        wait_drained();

        repeat (4) @(posedge i_clk);
        $display("checked %0d events: %0d frames completed, %0d timeouts, top byte index %0d",
                 n_checked, n_frames, n_timeouts, top_index);
        $display("covered reset values, directed slips, zero-length frames and idle mixes");
        if (errors == 0) begin
            $display("** sync_word_deframer_with_timeout_core: PASSED **");
        end else begin
            $display("** sync_word_deframer_with_timeout_core: FAILED **");
        end
        $finish;
    end

endmodule

### sync_word_deframer_with_timeout_core.f
hdl/sw_dfr_pkg.sv
hdl/sw_dfr_if.sv
hdl/sw_dfr_engine.sv
hdl/sw_dfr_obuf.sv
hdl/sync_word_deframer_with_timeout_core.sv
bench/tb.sv
